// ===== rtl/neighborhood_search_tuner_core_assert.svh =====
// Assertion macros used by the tuner datapath (nst_datapath).
`ifndef NEIGHBORHOOD_SEARCH_TUNER_CORE_ASSERT_SVH
`define NEIGHBORHOOD_SEARCH_TUNER_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define NST_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("nst assertion failed");
`define NST_ASSERT_NEXT(label, trig, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (prop)) \
    else $error("nst assertion failed");
`else
`define NST_ASSERT(label, prop)
`define NST_ASSERT_NEXT(label, trig, prop)
`endif
`endif

// ===== rtl/nst_pkg.sv =====
package nst_pkg;

  localparam int NODE_W      = 7;
  localparam int LEVEL_W     = 4;
  localparam int SCORE_W     = 32;
  localparam int OBJ_W       = 3;
  localparam int NLIM_W      = 7;
  localparam int NLEV_W      = 5;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 7;
  localparam int STACK_DEPTH = 9;
  localparam int STACK_CNT_W = $clog2(STACK_DEPTH + 1);
  localparam int STACK_IDX_W = $clog2(STACK_DEPTH);

  localparam int MAX_NODES_DEF   = 64;
  localparam int FREQ_LEVELS_DEF = 16;

  localparam logic signed [SCORE_W-1:0] BEST_FORGOTTEN = 32'hFFFF_0000;
  localparam logic [NLIM_W-1:0] NODE_LIMIT_RST       = 7'd64;
  localparam logic [NLEV_W-1:0] FREQ_LEVEL_COUNT_RST = 5'd16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NODE_LIMIT       = 1'b0,
    CFG_FREQ_LEVEL_COUNT = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    STEP_DOWN = 2'd0,
    STEP_HOLD = 2'd1,
    STEP_UP   = 2'd2
  } step_t;

  typedef struct packed {
    logic [NODE_W-1:0]         cur_nodes;
    logic [LEVEL_W-1:0]        cur_freq_level;
    logic signed [SCORE_W-1:0] score;
    logic [OBJ_W-1:0]          objective_id;
  } in_item_t;

  typedef struct packed {
    logic latch_in;
    logic update_best;
    logic gen_step;
    logic gen_done;
    logic pop;
  } cmd_t;

  typedef struct packed {
    logic stack_empty;
    logic gen_last;
    logic out_free;
  } status_t;

endpackage

// ===== rtl/nst_if.sv =====
interface nst_in_if;
  logic                                  valid;
  logic                                  ready;
  logic [nst_pkg::NODE_W-1:0]            cur_nodes;
  logic [nst_pkg::LEVEL_W-1:0]           cur_freq_level;
  logic signed [nst_pkg::SCORE_W-1:0]    score;
  logic [nst_pkg::OBJ_W-1:0]             objective_id;

  modport source (output valid, cur_nodes, cur_freq_level, score, objective_id, input ready);
  modport sink (input valid, cur_nodes, cur_freq_level, score, objective_id, output ready);
endinterface

interface nst_out_if;
  logic                        valid;
  logic                        ready;
  logic [nst_pkg::NODE_W-1:0]  next_nodes;
  logic [nst_pkg::LEVEL_W-1:0] next_freq_level;

  modport source (output valid, next_nodes, next_freq_level, input ready);
  modport sink (input valid, next_nodes, next_freq_level, output ready);
endinterface

// ===== rtl/nst_ctrl.sv =====
module nst_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  nst_pkg::status_t status,
  output nst_pkg::cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_UPDATE = 4'b0010,
    S_GEN    = 4'b0100,
    S_POP    = 4'b1000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next      = state;
    cmd             = '0;
    in_ready        = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready     = 1'b1;
        cmd.latch_in = in_valid;
        if (in_valid) begin
          state_next = S_UPDATE;
        end
      end
      S_UPDATE: begin
        cmd.update_best = 1'b1;
        state_next      = status.stack_empty ? S_GEN : S_POP;
      end
      S_GEN: begin
        cmd.gen_step = 1'b1;
        if (status.gen_last) begin
          cmd.gen_done = 1'b1;
          state_next   = S_POP;
        end
      end
      S_POP: begin
        if (status.out_free) begin
          cmd.pop    = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/nst_datapath.sv =====
`include "neighborhood_search_tuner_core_assert.svh"

module nst_datapath #(
  parameter int MAX_NODES   = nst_pkg::MAX_NODES_DEF,
  parameter int FREQ_LEVELS = nst_pkg::FREQ_LEVELS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [nst_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [nst_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  nst_pkg::in_item_t                 in_item,
  input  nst_pkg::cmd_t                     cmd,
  output nst_pkg::status_t                  status,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [nst_pkg::NODE_W-1:0]        next_nodes,
  output logic [nst_pkg::LEVEL_W-1:0]       next_freq_level
);

  localparam int NODE_CAP  = (MAX_NODES > 127) ? 127 : MAX_NODES;
  localparam int LEVEL_CAP = (FREQ_LEVELS > 16) ? 16 : FREQ_LEVELS;
  localparam logic [nst_pkg::NLIM_W-1:0] NODE_CAP_V  = nst_pkg::NLIM_W'(NODE_CAP);
  localparam logic [nst_pkg::NLEV_W-1:0] LEVEL_CAP_V = nst_pkg::NLEV_W'(LEVEL_CAP);
  localparam logic [nst_pkg::STACK_CNT_W-1:0] DEPTH_V =
    nst_pkg::STACK_CNT_W'(nst_pkg::STACK_DEPTH);

  logic [nst_pkg::NLIM_W-1:0]                 node_limit;
  logic [nst_pkg::NLEV_W-1:0]                 freq_level_count;
  nst_pkg::in_item_t                          item;
  logic [nst_pkg::OBJ_W-1:0]                  seen_objective;
  logic signed [nst_pkg::SCORE_W-1:0]         top_score;
  logic [nst_pkg::NODE_W-1:0]                 best_nodes;
  logic [nst_pkg::LEVEL_W-1:0]                best_freq_level;
  logic [nst_pkg::NODE_W-1:0]                 stack_nodes [nst_pkg::STACK_DEPTH];
  logic [nst_pkg::LEVEL_W-1:0]                stack_freq_level [nst_pkg::STACK_DEPTH];
  logic [nst_pkg::STACK_CNT_W-1:0]            stack_count;
  nst_pkg::step_t                             gen_dn;
  nst_pkg::step_t                             gen_df;

  logic signed [nst_pkg::SCORE_W-1:0]         eff_best;
  logic [nst_pkg::NLIM_W-1:0]                 lim;
  logic [nst_pkg::NLEV_W-1:0]                 levels;
  logic [nst_pkg::LEVEL_W-1:0]                top;
  logic [nst_pkg::NODE_W-1:0]                 bn;
  logic [nst_pkg::LEVEL_W-1:0]                bf;
  logic [nst_pkg::NODE_W-1:0]                 nb_nodes;
  logic [nst_pkg::LEVEL_W-1:0]                nb_level;
  logic                                       nb_valid;
  logic [nst_pkg::STACK_IDX_W-1:0]            wr_idx;
  logic [nst_pkg::STACK_IDX_W-1:0]            rd_idx;
  logic                                       do_push;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_limit       <= nst_pkg::NODE_LIMIT_RST;
      freq_level_count <= nst_pkg::FREQ_LEVEL_COUNT_RST;
    end else if (cfg_we) begin
      case (nst_pkg::cfg_reg_t'(cfg_index))
        nst_pkg::CFG_NODE_LIMIT:       node_limit <= cfg_data[nst_pkg::NLIM_W-1:0];
        nst_pkg::CFG_FREQ_LEVEL_COUNT: freq_level_count <= cfg_data[nst_pkg::NLEV_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign eff_best = (item.objective_id != seen_objective) ? nst_pkg::BEST_FORGOTTEN
                                                          : top_score;

  // Effective bounds, and the best setting clamped into them.
  always_comb begin
    lim = (node_limit > NODE_CAP_V) ? NODE_CAP_V : node_limit;
    if (lim == '0) begin
      lim = nst_pkg::NLIM_W'(1);
    end
    levels = (freq_level_count > LEVEL_CAP_V) ? LEVEL_CAP_V : freq_level_count;
    if (levels == '0) begin
      levels = nst_pkg::NLEV_W'(1);
    end
    top = nst_pkg::LEVEL_W'(levels - nst_pkg::NLEV_W'(1));
    bn  = best_nodes;
    if (bn == '0) begin
      bn = nst_pkg::NODE_W'(1);
    end
    if (bn > lim) begin
      bn = lim;
    end
    bf = (best_freq_level > top) ? top : best_freq_level;
  end

  always_comb begin
    nb_valid = 1'b1;
    nb_nodes = bn;
    nb_level = bf;
    case (gen_dn)
      nst_pkg::STEP_DOWN: begin
        nb_valid = bn > nst_pkg::NODE_W'(1);
        nb_nodes = bn - nst_pkg::NODE_W'(1);
      end
      nst_pkg::STEP_UP: begin
        nb_valid = bn < lim;
        nb_nodes = bn + nst_pkg::NODE_W'(1);
      end
      default: begin
      end
    endcase
    case (gen_df)
      nst_pkg::STEP_DOWN: begin
        nb_valid = nb_valid && (bf != '0);
        nb_level = bf - nst_pkg::LEVEL_W'(1);
      end
      nst_pkg::STEP_UP: begin
        nb_valid = nb_valid && (bf < top);
        nb_level = bf + nst_pkg::LEVEL_W'(1);
      end
      default: begin
      end
    endcase
  end

  assign do_push = cmd.gen_step && nb_valid && (stack_count < DEPTH_V);
  assign wr_idx  = stack_count[nst_pkg::STACK_IDX_W-1:0];
  assign rd_idx  = nst_pkg::STACK_IDX_W'(stack_count - nst_pkg::STACK_CNT_W'(1));

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      item <= in_item;
    end
    if (do_push) begin
      stack_nodes[wr_idx]      <= nb_nodes;
      stack_freq_level[wr_idx] <= nb_level;
    end
    if (cmd.pop) begin
      if (stack_count == '0) begin
        next_nodes      <= item.cur_nodes;
        next_freq_level <= item.cur_freq_level;
      end else begin
        next_nodes      <= stack_nodes[rd_idx];
        next_freq_level <= stack_freq_level[rd_idx];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_objective  <= '0;
      top_score       <= nst_pkg::BEST_FORGOTTEN;
      best_nodes      <= nst_pkg::NODE_W'(1);
      best_freq_level <= '0;
      stack_count     <= '0;
      gen_dn          <= nst_pkg::STEP_DOWN;
      gen_df          <= nst_pkg::STEP_DOWN;
      out_valid       <= 1'b0;
    end else begin
      if (cmd.update_best) begin
        seen_objective <= item.objective_id;
        top_score      <= (item.score > eff_best) ? item.score : eff_best;
        gen_dn         <= nst_pkg::STEP_DOWN;
        gen_df         <= nst_pkg::STEP_DOWN;
      end
      if (cmd.update_best && (item.score > eff_best)) begin
        best_nodes      <= item.cur_nodes;
        best_freq_level <= item.cur_freq_level;
      end
      if (cmd.gen_step) begin
        if (gen_df == nst_pkg::STEP_UP) begin
          gen_df <= nst_pkg::STEP_DOWN;
          gen_dn <= nst_pkg::step_t'(gen_dn + 2'd1);
        end else begin
          gen_df <= nst_pkg::step_t'(gen_df + 2'd1);
        end
      end
      if (cmd.gen_done) begin
        top_score <= '0;
      end
      if (do_push) begin
        stack_count <= stack_count + nst_pkg::STACK_CNT_W'(1);
      end else if (cmd.pop && (stack_count != '0)) begin
        stack_count <= stack_count - nst_pkg::STACK_CNT_W'(1);
      end
      if (cmd.pop) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign status.stack_empty = (stack_count == '0);
  assign status.gen_last    = (gen_dn == nst_pkg::STEP_UP) && (gen_df == nst_pkg::STEP_UP);
  assign status.out_free    = !out_valid || out_ready;

  `NST_ASSERT(a_stack_bound, stack_count <= DEPTH_V)
  `NST_ASSERT_NEXT(a_pop_shrinks, cmd.pop && (stack_count != '0),
    stack_count == nst_pkg::STACK_CNT_W'($past(stack_count) - nst_pkg::STACK_CNT_W'(1)))
  `NST_ASSERT_NEXT(a_gen_fills, cmd.gen_done, (stack_count != '0) && (top_score == '0))
  `NST_ASSERT(a_pop_needs_room, cmd.pop |-> status.out_free)

endmodule

// ===== rtl/neighborhood_search_tuner_core.sv =====
// Hill-climbing tuner over (node count, frequency level). Each input beat carries the
// setting just measured, its score and the objective id; one output beat returns the
// setting to try next. The input is taken only while the controller is idle. When the
// explore stack holds entries, an item goes through latch, best-score update and pop
// into the output register before the next beat can be taken. When the stack is
// empty, the controller first walks the nine neighbour positions of the best setting,
// one per cycle, before the pop. The output register lets the next beat enter while a
// result still waits; a pop waits for that register to be free. Configuration writes
// are taken in any cycle but are meant for idle time.
module neighborhood_search_tuner_core #(
  parameter int MAX_NODES   = nst_pkg::MAX_NODES_DEF,
  parameter int FREQ_LEVELS = nst_pkg::FREQ_LEVELS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  nst_in_if.sink                         in_ch,
  nst_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [nst_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [nst_pkg::CFG_DATA_W-1:0] cfg_data
);

  nst_pkg::cmd_t     cmd;
  nst_pkg::status_t  status;
  nst_pkg::in_item_t in_item;

  assign in_item.cur_nodes      = in_ch.cur_nodes;
  assign in_item.cur_freq_level = in_ch.cur_freq_level;
  assign in_item.score          = in_ch.score;
  assign in_item.objective_id   = in_ch.objective_id;

  nst_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  nst_datapath #(
    .MAX_NODES   (MAX_NODES),
    .FREQ_LEVELS (FREQ_LEVELS)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_item         (in_item),
    .cmd             (cmd),
    .status          (status),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .next_nodes      (out_ch.next_nodes),
    .next_freq_level (out_ch.next_freq_level)
  );

endmodule
